>>> hdl/tpip_pkg.sv
// ----------------------------------------------------------------------------
// Two-ray point-in-polygon package
// Shared widths, opcodes and control structs for the polygon test block.
// ----------------------------------------------------------------------------
package tpip_pkg;

    localparam int MAX_VERTS_DEF = 16;
    localparam int COORD_W       = 16;
    localparam int PT_W          = 32;
    localparam int SCALE_W       = 16;
    localparam int VERT_W        = 2 * COORD_W;

    localparam int DIV_BITS  = 4;
    localparam int DIV_STEPS = PT_W / DIV_BITS;

    localparam int DIFF_W = COORD_W + 1;
    localparam int AC_W   = PT_W + 1;
    localparam int RAY_W  = 15;
    localparam int PROD_W = AC_W + DIFF_W;
    localparam int KCD_W  = DIFF_W + RAY_W - 1;
    localparam int KAC_W  = AC_W + RAY_W - 1;
    localparam int SUM_W  = PROD_W + 2;

    localparam logic signed [RAY_W-1:0] RAY_LEN = 15'sd10000;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_QUERY  = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    typedef struct packed {
        logic valid;
        logic last;
    } edge_ctl_t;

    typedef struct packed {
        logic valid;
        logic last;
        logic hit_left;
        logic hit_right;
    } edge_res_t;

endpackage

>>> hdl/tpip_store.sv
// ----------------------------------------------------------------------------
// Vertex memory
// Synchronous memory holding one packed x/z vertex per entry, with a registered read.
// ----------------------------------------------------------------------------
module tpip_store
    import tpip_pkg::*;
#(
    parameter int DEPTH = MAX_VERTS_DEF,
    parameter int AW    = $clog2(MAX_VERTS_DEF)
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [VERT_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output logic [VERT_W-1:0] rd_data
);

    logic [VERT_W-1:0] mem [0:DEPTH-1];
    logic [VERT_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/tpip_div.sv
// ----------------------------------------------------------------------------
// Floor divider
// Signed 32-bit by unsigned 16-bit division rounding toward minus infinity,
// four quotient bits per cycle.
// ----------------------------------------------------------------------------
module tpip_div
    import tpip_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic signed [PT_W-1:0] dividend,
    input  logic [SCALE_W-1:0]     divisor,
    output logic                   done,
    output logic signed [PT_W-1:0] quotient
);

    localparam int SW = $clog2(DIV_STEPS);

    logic               run_reg, run_next;
    logic               done_reg, done_next;
    logic [SW-1:0]      step_reg, step_next;
    logic               neg_reg;
    logic [PT_W-1:0]    quo_reg, quo_next;
    logic [SCALE_W-1:0] rem_reg, rem_next;
    logic [SCALE_W-1:0] dsr_reg;

    always_comb
    begin
        logic [SCALE_W:0]   trial;
        logic [PT_W-1:0]    q;
        logic [SCALE_W-1:0] r;
        q = quo_reg;
        r = rem_reg;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            trial = {r, q[PT_W-1]};
            q = {q[PT_W-2:0], 1'b0};
            if (trial >= {1'b0, dsr_reg})
            begin
                trial = trial - {1'b0, dsr_reg};
                q[0] = 1'b1;
            end
            r = trial[SCALE_W-1:0];
        end
        quo_next = q;
        rem_next = r;
    end

    always_comb
    begin
        run_next  = run_reg;
        step_next = step_reg;
        done_next = 1'b0;
        if (start)
        begin
            run_next  = 1'b1;
            step_next = '0;
        end
        else if (run_reg)
        begin
            step_next = step_reg + 1'b1;
            if (step_reg == SW'(DIV_STEPS - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[PT_W-1];
            quo_reg <= dividend[PT_W-1] ? PT_W'(-dividend) : PT_W'(dividend);
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (run_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    // A negative dividend with a remainder rounds one further down: -q - 1 = ~q.
    assign quotient = !neg_reg ? signed'(quo_reg) :
                      (rem_reg != '0) ? signed'(~quo_reg) : signed'(-quo_reg);
    assign done = done_reg;

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("divider done held for more than one cycle");

    a_run_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg |-> dsr_reg != '0)
        else $error("divider running with a zero divisor");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !run_reg)
        else $error("divider started while a division is running");

endmodule

>>> hdl/tpip_edge.sv
// ----------------------------------------------------------------------------
// Edge crossing pipeline
// Four-stage test of one polygon edge against the left and right rays.
// ----------------------------------------------------------------------------
module tpip_edge
    import tpip_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  edge_ctl_t                 in_ctl,
    input  logic signed [PT_W-1:0]    px,
    input  logic signed [PT_W-1:0]    pz,
    input  logic signed [COORD_W-1:0] cx,
    input  logic signed [COORD_W-1:0] cz,
    input  logic signed [COORD_W-1:0] dx,
    input  logic signed [COORD_W-1:0] dz,
    output edge_res_t                 out_res
);

    function automatic logic seg_hit(input logic signed [SUM_W-1:0] den,
                                     input logic signed [SUM_W-1:0] na,
                                     input logic signed [SUM_W-1:0] nb);
        logic res;
        res = 1'b0;
        if (den > 0)
        begin
            res = (na >= 0) && (nb >= 0) && (na <= den) && (nb <= den);
        end
        else if (den < 0)
        begin
            res = (na <= 0) && (nb <= 0) && (na >= den) && (nb >= den);
        end
        return res;
    endfunction

    edge_ctl_t ctl1_reg, ctl2_reg, ctl3_reg;
    edge_res_t res_reg, res_next;

    logic signed [DIFF_W-1:0] xcd_reg, zcd_reg;
    logic signed [AC_W-1:0]   xac_reg, zac_reg;

    logic signed [PROD_W-1:0] pna_reg, t_reg;
    logic signed [KCD_W-1:0]  kcd_reg;
    logic signed [KAC_W-1:0]  kac_reg;

    logic signed [SUM_W-1:0]  den_l_reg, den_r_reg, na_reg, nb_l_reg, nb_r_reg;

    always_ff @(posedge clk)
    begin
        xcd_reg <= DIFF_W'(cx) - DIFF_W'(dx);
        zcd_reg <= DIFF_W'(cz) - DIFF_W'(dz);
        xac_reg <= AC_W'(px) - AC_W'(cx);
        zac_reg <= AC_W'(pz) - AC_W'(cz);

        pna_reg <= xac_reg * zcd_reg;
        t_reg   <= xcd_reg * zac_reg;
        kcd_reg <= zcd_reg * RAY_LEN;
        kac_reg <= zac_reg * RAY_LEN;

        den_l_reg <= SUM_W'(kcd_reg) - SUM_W'(t_reg);
        den_r_reg <= -SUM_W'(kcd_reg) - SUM_W'(t_reg);
        na_reg    <= SUM_W'(pna_reg) - SUM_W'(t_reg);
        nb_l_reg  <= -SUM_W'(kac_reg);
        nb_r_reg  <= SUM_W'(kac_reg);
    end

    always_comb
    begin
        res_next.valid     = ctl3_reg.valid;
        res_next.last      = ctl3_reg.last;
        res_next.hit_left  = seg_hit(den_l_reg, na_reg, nb_l_reg);
        res_next.hit_right = seg_hit(den_r_reg, na_reg, nb_r_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
            res_reg  <= '0;
        end
        else
        begin
            ctl1_reg <= in_ctl;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
            res_reg  <= res_next;
        end
    end

    assign out_res = res_reg;

endmodule

>>> hdl/two_ray_point_in_polygon.sv
// ----------------------------------------------------------------------------
// Two-ray point-in-polygon test
//
// A request is taken when start is high and busy is low. Opcode clear empties
// the polygon and opcode append stores one vertex; both finish in the cycle
// they are taken and give no result. A full polygon ignores appends. Opcode
// query floor-divides the point by cover_scale, walks every stored edge
// including the closing edge, and raises done for one cycle with inside_res.
// A query runs the radix-16 divider, latches the grid point, reads the vertex
// memory N + 1 times for N stored vertices (one read per cycle, the first
// vertex read again to close the polygon), passes the memory read and the
// edge pipeline and ends with the done strobe. An empty polygon raises done
// with inside_res low once the divider finishes. busy is high until the
// result is on the ports; the receiver cannot stall, so the result is never
// held. cover_scale is written through cfg_wr_en and cfg_wr_data while the
// block is idle; the user is bound to this, the block does not enforce it.
// Reset empties the polygon and sets cover_scale to 1; memory is not cleared.
// ----------------------------------------------------------------------------
module two_ray_point_in_polygon
    import tpip_pkg::*;
#(
    parameter int MAX_VERTS = MAX_VERTS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                opcode,
    input  logic signed [COORD_W-1:0] vertex_x,
    input  logic signed [COORD_W-1:0] vertex_z,
    input  logic signed [PT_W-1:0]    point_x,
    input  logic signed [PT_W-1:0]    point_z,
    input  logic                      cfg_wr_en,
    input  logic [SCALE_W-1:0]        cfg_wr_data,
    output logic                      done,
    output logic                      inside_res
);

    localparam int AW = $clog2(MAX_VERTS);
    localparam int CW = $clog2(MAX_VERTS + 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_DIV   = 4'b0010,
        S_WALK  = 4'b0100,
        S_DRAIN = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [SCALE_W-1:0] scale_reg;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      rd_cnt_reg, rd_cnt_next;
    logic               rd_valid_reg, rd_first_reg, rd_last_reg;
    logic               left_reg, left_next;
    logic               right_reg, right_next;
    logic               done_reg, done_next;
    logic               inside_reg, inside_next;
    logic signed [PT_W-1:0] px_reg, pz_reg;
    logic [VERT_W-1:0]  prev_reg;

    logic               accept;
    logic               wr_en;
    logic               rd_en;
    logic               rd_first;
    logic               rd_last;
    logic [AW-1:0]      rd_addr;
    logic [VERT_W-1:0]  rd_data;
    logic [SCALE_W-1:0] divisor;
    logic               div_start;
    logic               div_done_x;
    logic               div_done_z;
    logic signed [PT_W-1:0] qx;
    logic signed [PT_W-1:0] qz;
    edge_ctl_t          edge_ctl;
    edge_res_t          edge_res;

    assign accept    = start && !busy;
    assign wr_en     = accept && (opcode == OP_APPEND) && (count_reg < CW'(MAX_VERTS));
    assign div_start = accept && (opcode == OP_QUERY);
    assign divisor   = (scale_reg == '0) ? SCALE_W'(1) : scale_reg;

    assign rd_en    = (state_reg == S_WALK);
    assign rd_first = (rd_cnt_reg == '0);
    assign rd_last  = (rd_cnt_reg == count_reg);
    assign rd_addr  = rd_last ? '0 : rd_cnt_reg[AW-1:0];

    tpip_store #(
        .DEPTH (MAX_VERTS),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data ({vertex_x, vertex_z}),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    tpip_div u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (point_x),
        .divisor  (divisor),
        .done     (div_done_x),
        .quotient (qx)
    );

    tpip_div u_div_z (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (point_z),
        .divisor  (divisor),
        .done     (div_done_z),
        .quotient (qz)
    );

    assign edge_ctl.valid = rd_valid_reg && !rd_first_reg;
    assign edge_ctl.last  = rd_last_reg;

    tpip_edge u_edge (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ctl  (edge_ctl),
        .px      (px_reg),
        .pz      (pz_reg),
        .cx      (signed'(prev_reg[VERT_W-1:COORD_W])),
        .cz      (signed'(prev_reg[COORD_W-1:0])),
        .dx      (signed'(rd_data[VERT_W-1:COORD_W])),
        .dz      (signed'(rd_data[COORD_W-1:0])),
        .out_res (edge_res)
    );

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        rd_cnt_next = rd_cnt_reg;
        left_next   = left_reg;
        right_next  = right_reg;
        done_next   = 1'b0;
        inside_next = inside_reg;

        if (edge_res.valid)
        begin
            left_next  = left_reg || edge_res.hit_left;
            right_next = right_reg || edge_res.hit_right;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (opcode)
                        OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        OP_APPEND:
                        begin
                            if (wr_en)
                            begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_QUERY:
                        begin
                            left_next  = 1'b0;
                            right_next = 1'b0;
                            state_next = S_DIV;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_DIV:
            begin
                if (div_done_x)
                begin
                    rd_cnt_next = '0;
                    if (count_reg == '0)
                    begin
                        done_next   = 1'b1;
                        inside_next = 1'b0;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_WALK;
                    end
                end
            end
            S_WALK:
            begin
                rd_cnt_next = rd_cnt_reg + 1'b1;
                if (rd_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (edge_res.valid && edge_res.last)
                begin
                    done_next   = 1'b1;
                    inside_next = left_next && right_next;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            scale_reg    <= SCALE_W'(1);
            count_reg    <= '0;
            rd_cnt_reg   <= '0;
            rd_valid_reg <= 1'b0;
            rd_first_reg <= 1'b0;
            rd_last_reg  <= 1'b0;
            left_reg     <= 1'b0;
            right_reg    <= 1'b0;
            done_reg     <= 1'b0;
            inside_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            rd_cnt_reg   <= rd_cnt_next;
            rd_valid_reg <= rd_en;
            rd_first_reg <= rd_en && rd_first;
            rd_last_reg  <= rd_en && rd_last;
            left_reg     <= left_next;
            right_reg    <= right_next;
            done_reg     <= done_next;
            inside_reg   <= inside_next;
            if (cfg_wr_en)
            begin
                scale_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_done_x)
        begin
            px_reg <= qx;
        end
        if (div_done_z)
        begin
            pz_reg <= qz;
        end
        if (rd_valid_reg)
        begin
            prev_reg <= rd_data;
        end
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign inside_res = inside_reg;

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && opcode == OP_QUERY) |=> busy)
        else $error("query request did not make the block busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result given without a query in progress");

    a_edge_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        edge_res.valid |-> (state_reg == S_WALK || state_reg == S_DRAIN))
        else $error("edge result outside the polygon walk");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_VERTS))
        else $error("vertex count beyond capacity");

endmodule

>>> bench/two_ray_point_in_polygon_tb.sv
// ----------------------------------------------------------------------------
// Two-ray point-in-polygon testbench
// Drives clear, append, query and unused requests into the polygon block with
// bursty pacing and random cover_scale settings. It predicts each query
// answer from its own copy of the polygon and checks every done strobe
// against the oldest pending answer.
// ----------------------------------------------------------------------------
module two_ray_point_in_polygon_tb
    import tpip_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     WATCHDOG_LIMIT = 2000;
    localparam int     SETTLE_CYCLES  = MAX_VERTS_DEF + 24;
    localparam int     TARGET_ITEMS   = 1950;
    localparam longint RAY_REACH      = 10000;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic [1:0]                opcode;
    logic signed [COORD_W-1:0] vertex_x;
    logic signed [COORD_W-1:0] vertex_z;
    logic signed [PT_W-1:0]    point_x;
    logic signed [PT_W-1:0]    point_z;
    logic                      cfg_wr_en;
    logic [SCALE_W-1:0]        cfg_wr_data;
    logic                      done;
    logic                      inside_res;

    logic signed [COORD_W-1:0] poly_x [MAX_VERTS_DEF];
    logic signed [COORD_W-1:0] poly_z [MAX_VERTS_DEF];
    int                        poly_count;
    logic [SCALE_W-1:0]        grid_scale;

    bit  pending_inside [$];
    int  error_count;
    int  items_sent;
    int  idle_cycles;
    int  burst_left;
    bit  steady;
    bit  start_q;

    two_ray_point_in_polygon #(
        .MAX_VERTS(MAX_VERTS_DEF)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .opcode     (opcode),
        .vertex_x   (vertex_x),
        .vertex_z   (vertex_z),
        .point_x    (point_x),
        .point_z    (point_z),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .done       (done),
        .inside_res (inside_res)
    );

    always #10 clk = ~clk;

    function automatic longint floor_quot(input longint a, input longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0)
        begin
            q = q - 1;
        end
        return q;
    endfunction

    function automatic bit ray_crosses(input longint ax, input longint az,
                                       input longint bx, input longint bz,
                                       input longint cx, input longint cz,
                                       input longint dx, input longint dz);
        longint xab;
        longint zab;
        longint xcd;
        longint zcd;
        longint xac;
        longint zac;
        longint den;
        longint na;
        longint nb;
        xab = ax - bx;
        zab = az - bz;
        xcd = cx - dx;
        zcd = cz - dz;
        xac = ax - cx;
        zac = az - cz;
        // The denominator uses the AC z-difference on purpose.
        den = xab * zcd - xcd * zac;
        if (den == 0)
        begin
            return 1'b0;
        end
        na = xac * zcd - xcd * zac;
        nb = xac * zab - xab * zac;
        if (den < 0)
        begin
            den = -den;
            na = -na;
            nb = -nb;
        end
        return na >= 0 && nb >= 0 && den >= na && den >= nb;
    endfunction

    function automatic int rand_coord(input int center, input int span);
        return center - span + int'($urandom_range(0, 2 * span));
    endfunction

    function automatic logic [PT_W-1:0] to_world(input int g);
        longint s;
        longint w;
        s = (grid_scale == 0) ? 1 : longint'(grid_scale);
        w = longint'(g) * s + longint'($urandom_range(0, int'(s) - 1));
        if (w > 64'sd2147483647)
        begin
            w = 64'sd2147483647;
        end
        if (w < -64'sd2147483648)
        begin
            w = -64'sd2147483648;
        end
        return w[PT_W-1:0];
    endfunction

    task automatic release_start();
        if (start_q)
        begin
            start <= 1'b0;
            start_q = 1'b0;
        end
    endtask

    task automatic pace();
        if (steady)
        begin
            return;
        end
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            release_start();
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(0, 24);
        end
    endtask

    task automatic send_request(input opcode_t op,
                                input logic signed [COORD_W-1:0] vx,
                                input logic signed [COORD_W-1:0] vz,
                                input logic signed [PT_W-1:0] px,
                                input logic signed [PT_W-1:0] pz);
        longint eff;
        longint gx;
        longint gz;
        bit     hit_left;
        bit     hit_right;
        int     k;
        start    <= 1'b1;
        start_q   = 1'b1;
        opcode   <= op;
        vertex_x <= vx;
        vertex_z <= vz;
        point_x  <= px;
        point_z  <= pz;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        case (op)
            OP_CLEAR:
            begin
                poly_count = 0;
            end
            OP_APPEND:
            begin
                if (poly_count < MAX_VERTS_DEF)
                begin
                    poly_x[poly_count] = vx;
                    poly_z[poly_count] = vz;
                    poly_count++;
                end
            end
            OP_QUERY:
            begin
                eff = (grid_scale == 0) ? 1 : longint'(grid_scale);
                gx = floor_quot(longint'(px), eff);
                gz = floor_quot(longint'(pz), eff);
                hit_left = 1'b0;
                hit_right = 1'b0;
                for (int j = 0; j < poly_count; j++)
                begin
                    k = (j + 1 < poly_count) ? j + 1 : 0;
                    if (ray_crosses(gx, gz, gx - RAY_REACH, gz,
                                    longint'(poly_x[j]), longint'(poly_z[j]),
                                    longint'(poly_x[k]), longint'(poly_z[k])))
                    begin
                        hit_left = 1'b1;
                    end
                    if (ray_crosses(gx, gz, gx + RAY_REACH, gz,
                                    longint'(poly_x[j]), longint'(poly_z[j]),
                                    longint'(poly_x[k]), longint'(poly_z[k])))
                    begin
                        hit_right = 1'b1;
                    end
                end
                pending_inside.push_back(hit_left && hit_right);
            end
            default:
            begin
            end
        endcase
        if (op != OP_NONE)
        begin
            items_sent++;
        end
        pace();
    endtask

    task automatic write_scale(input logic [SCALE_W-1:0] value);
        release_start();
        do
        begin
            @(posedge clk);
        end
        while (pending_inside.size() != 0 || busy);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en  <= 1'b0;
        grid_scale  = value;
    endtask

    task automatic test_empty_polygon();
        send_request(OP_QUERY, 16'sd0, 16'sd0, 32'sd0, 32'sd0);
        send_request(OP_NONE, 16'sh7FFF, -16'sd1, 32'sh7FFFFFFF, -32'sd1);
        send_request(OP_QUERY, 16'sd0, 16'sd0, 32'sd5, -32'sd5);
    endtask

    task automatic test_square();
        send_request(OP_CLEAR, 16'sd0, 16'sd0, 32'sd0, 32'sd0);
        send_request(OP_APPEND, -16'sd100, -16'sd100, 32'sd0, 32'sd0);
        send_request(OP_APPEND, 16'sd100, -16'sd100, 32'sd0, 32'sd0);
        // A repeated corner gives a zero-length edge.
        send_request(OP_APPEND, 16'sd100, 16'sd100, 32'sd0, 32'sd0);
        send_request(OP_APPEND, 16'sd100, 16'sd100, 32'sd0, 32'sd0);
        send_request(OP_APPEND, -16'sd100, 16'sd100, 32'sd0, 32'sd0);
        send_request(OP_QUERY, 16'sd0, 16'sd0, 32'sd0, 32'sd0);
        send_request(OP_QUERY, 16'sd0, 16'sd0, 32'sd500, 32'sd0);
        // The point lies on the line of a horizontal edge.
        send_request(OP_QUERY, 16'sd0, 16'sd0, 32'sd0, -32'sd100);
    endtask

    task automatic test_full_polygon();
        for (int i = 0; i < 12; i++)
        begin
            send_request(OP_APPEND, (i % 2 == 0) ? -16'sd32768 : 16'sd32767,
                         (i % 4 < 2) ? 16'sd32767 : -16'sd32768, 32'sd0, 32'sd0);
        end
        send_request(OP_QUERY, 16'sd0, 16'sd0, 32'sd20, -32'sd20);
    endtask

    task automatic test_scale_extremes();
        write_scale(16'd0);
        send_request(OP_QUERY, 16'sd0, 16'sd0, 32'sd150, -32'sd150);
        write_scale(16'hFFFF);
        send_request(OP_QUERY, 16'sd0, 16'sd0, 32'sh7FFFFFFF, 32'sh80000000);
        send_request(OP_QUERY, 16'sd0, 16'sd0, 32'sh80000000, 32'sh7FFFFFFF);
        write_scale(16'd1);
    endtask

    task automatic test_random_traffic();
        int span;
        int center;
        int n_verts;
        int n_queries;
        int pick;
        int gx;
        int gz;
        while (items_sent < TARGET_ITEMS)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                case ($urandom_range(0, 5))
                    0: write_scale(16'd1);
                    1: write_scale(16'd0);
                    2: write_scale(16'hFFFF);
                    3: write_scale(16'($urandom_range(2, 16)));
                    default: write_scale(16'($urandom_range(1, 65535)));
                endcase
            end
            if ($urandom_range(0, 3) == 0)
            begin
                steady = ~steady;
            end
            if ($urandom_range(0, 99) < 85)
            begin
                pick = $urandom_range(0, 9);
                span = (pick < 6) ? 200 : (pick < 9) ? 3000 : 32767;
                center = rand_coord(0, 32767 - span);
                pick = $urandom_range(0, 19);
                n_verts = (pick < 14) ? $urandom_range(3, 8) :
                          (pick < 17) ? $urandom_range(0, 2) : $urandom_range(9, 18);
                send_request(OP_CLEAR, 16'($urandom()), 16'($urandom()),
                             32'($urandom()), 32'($urandom()));
                for (int i = 0; i < n_verts; i++)
                begin
                    send_request(OP_APPEND, 16'(rand_coord(center, span)),
                                 16'(rand_coord(center, span)),
                                 32'($urandom()), 32'($urandom()));
                end
                n_queries = $urandom_range(2, 10);
                for (int i = 0; i < n_queries; i++)
                begin
                    if (poly_count > 0 && $urandom_range(0, 6) == 0)
                    begin
                        pick = $urandom_range(0, poly_count - 1);
                        gx = int'(poly_x[pick]);
                        gz = int'(poly_z[pick]);
                    end
                    else
                    begin
                        gx = rand_coord(center, span + span / 4);
                        gz = rand_coord(center, span + span / 4);
                    end
                    send_request(OP_QUERY, 16'($urandom()), 16'($urandom()),
                                 to_world(gx), to_world(gz));
                end
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                begin
                    send_request(opcode_t'($urandom_range(0, 3)), 16'($urandom()),
                                 16'($urandom()), 32'($urandom()), 32'($urandom()));
                end
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_inside.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result, expected none, got inside_res %0b",
                         $time, inside_res);
            end
            else if (inside_res !== pending_inside[0])
            begin
                error_count++;
                $display("%0t: inside_res mismatch, expected %0b, got %0b",
                         $time, pending_inside[0], inside_res);
                void'(pending_inside.pop_front());
            end
            else
            begin
                void'(pending_inside.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || cfg_wr_en)
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("two_ray_point_in_polygon_tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        rst_n       <= 1'b0;
        start       <= 1'b0;
        opcode      <= OP_CLEAR;
        vertex_x    <= '0;
        vertex_z    <= '0;
        point_x     <= '0;
        point_z     <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        start_q      = 1'b0;
        poly_count   = 0;
        grid_scale   = 16'd1;
        error_count  = 0;
        items_sent   = 0;
        idle_cycles  = 0;
        burst_left   = $urandom_range(0, 24);
        steady       = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_polygon();
        test_square();
        test_full_polygon();
        test_scale_extremes();
        test_random_traffic();

        release_start();
        do
        begin
            @(posedge clk);
        end
        while (pending_inside.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
        begin
            $display("two_ray_point_in_polygon_tb: done, clean");
        end
        else
        begin
            $display("two_ray_point_in_polygon_tb: done, errors");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/tpip_pkg.sv
hdl/tpip_store.sv
hdl/tpip_div.sv
hdl/tpip_edge.sv
hdl/two_ray_point_in_polygon.sv
bench/two_ray_point_in_polygon_tb.sv
